FILE: hw/rtl/bsat_pkg.sv
// Package for the bank switch address translator.
// Holds the sizes, item codes and controller/datapath interface structs.
// No dependencies; every other file of the block imports it.
package bsat_pkg;

    // Table sizes and widths
    localparam int PRG_SLOTS        = 4;
    localparam int CHR_SLOTS        = 8;
    localparam int ROM_ADDRESS_BITS = 20;
    localparam int OFFSET_W         = 20;
    localparam int PRG_BANKS_W      = 8;
    localparam int CHR_BANKS_W      = 11;
    localparam int CFG_DATA_W       = 11;
    localparam int SUM_W = ((ROM_ADDRESS_BITS > OFFSET_W) ? ROM_ADDRESS_BITS : OFFSET_W) + 1;

    // Remainder unit: magnitude bits of the bank position and its step counter
    localparam int DIV_W     = 15;
    localparam int DIV_CNT_W = 4;

    // Item kinds
    localparam logic [1:0] KIND_PRG_XLATE = 2'd0;
    localparam logic [1:0] KIND_CHR_XLATE = 2'd1;
    localparam logic [1:0] KIND_PRG_SET   = 2'd2;
    localparam logic [1:0] KIND_CHR_SET   = 2'd3;

    // Result targets
    localparam logic [1:0] TARGET_PRG_ROM = 2'd0;
    localparam logic [1:0] TARGET_PRG_RAM = 2'd1;
    localparam logic [1:0] TARGET_CHR_ROM = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PRG_ROM_BANKS = 1'b0;
    localparam logic CFG_CHR_ROM_BANKS = 1'b1;

    // Program window size that a set item ignores
    localparam logic [1:0] PRG_WS_INVALID = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the accepted word
        logic xlate;       // produce the translate result
        logic elem_start;  // load the remainder unit for one slot
        logic div_step;    // one restoring remainder step
        logic elem_write;  // wrap, store the slot, advance the slot count
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic skip;        // program set with an unsupported window size
        logic div_last;    // last remainder step this cycle
        logic elem_last;   // last slot of the window
    } ctl_status_t;

endpackage

FILE: hw/rtl/bsat_ctrl.sv
// Controller state machine of the bank switch address translator.
// Sequences translate words and the per-slot remainder loop of set words.
// Depends on bsat_pkg.
module bsat_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            kind,
    input  bsat_pkg::ctl_status_t status,
    output bsat_pkg::ctl_cmd_t    cmd,
    output logic                  busy
);
    import bsat_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_XLATE = 5'b00010,
        ST_PREP  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_set;

    assign is_set = (kind == KIND_PRG_SET) || (kind == KIND_CHR_SET);
    assign busy   = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = is_set ? ST_PREP : ST_XLATE;
                end
            end
            ST_XLATE:
            begin
                cmd.xlate  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_PREP:
            begin
                if (status.skip)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.elem_start = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.elem_write = 1'b1;
                state_next     = status.elem_last ? ST_IDLE : ST_PREP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/bsat_datapath.sv
// Datapath of the bank switch address translator: size registers, slot tables,
// the restoring remainder unit for bank wrap and the translate result register.
// Depends on bsat_pkg.
module bsat_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bsat_pkg::ctl_cmd_t                  cmd,
    output bsat_pkg::ctl_status_t               status,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [bsat_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                          kind,
    input  logic [15:0]                         address,
    input  logic [1:0]                          window_size,
    input  logic [2:0]                          slot,
    input  logic signed [10:0]                  page,
    output logic                                done,
    output logic [bsat_pkg::OFFSET_W-1:0]       offset,
    output logic [1:0]                          target,
    output logic                                out_of_range
);
    import bsat_pkg::*;

    // Configuration and slot tables
    logic [PRG_BANKS_W-1:0]      prg_banks_reg;
    logic [CHR_BANKS_W-1:0]      chr_banks_reg;
    logic [ROM_ADDRESS_BITS-1:0] prg_slots_reg [PRG_SLOTS];
    logic [ROM_ADDRESS_BITS-1:0] chr_slots_reg [CHR_SLOTS];

    // Captured word
    logic [1:0]  kind_reg;
    logic [15:0] address_reg;
    logic [1:0]  ws_reg;
    logic [2:0]  slot_reg;
    logic [10:0] page_reg;

    // Slot loop and remainder unit
    logic [2:0]             elem_reg;
    logic [DIV_CNT_W-1:0]   count_reg;
    logic [DIV_W-1:0]       dividend_reg;
    logic [CHR_BANKS_W-1:0] rem_reg;
    logic                   neg_reg;

    // Result registers
    logic                done_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [1:0]          target_reg;
    logic                oor_reg;

    logic                   is_chr;
    logic [CHR_BANKS_W-1:0] modulus;
    logic [11:0]            page_adj;
    logic [15:0]            bank_pos;
    logic [15:0]            bank_mag;
    logic [CHR_BANKS_W:0]   trial;
    logic [CHR_BANKS_W-1:0] wrapped;
    logic [5:0]             slot_idx;
    logic [2:0]             elem_mask;
    logic [ROM_ADDRESS_BITS-1:0] slot_value;
    logic [SUM_W-1:0]       prg_sum;
    logic [SUM_W-1:0]       chr_sum;

    assign is_chr  = (kind_reg == KIND_CHR_SET);
    assign modulus = is_chr ? chr_banks_reg : CHR_BANKS_W'(prg_banks_reg);

    // Negative program page counts back from the end of the ROM
    always_comb
    begin
        page_adj = {page_reg[10], page_reg};
        if (!is_chr && page_reg[10])
        begin
            page_adj = page_adj + 12'(prg_banks_reg >> ws_reg);
        end
    end

    // Bank position of this slot in ROM bank units, and its magnitude
    assign bank_pos = ({{4{page_adj[11]}}, page_adj} << ws_reg) + {13'b0, elem_reg};
    assign bank_mag = bank_pos[15] ? (16'd0 - bank_pos) : bank_pos;

    // Restoring remainder step
    assign trial = {rem_reg, dividend_reg[DIV_W-1]};

    // Floored wrap; an empty ROM maps to offset zero
    always_comb
    begin
        if (modulus == '0)
        begin
            wrapped = '0;
        end
        else if (neg_reg && (rem_reg != '0))
        begin
            wrapped = modulus - rem_reg;
        end
        else
        begin
            wrapped = rem_reg;
        end
    end

    assign slot_value = is_chr ? ROM_ADDRESS_BITS'({wrapped, 10'b0})
                               : ROM_ADDRESS_BITS'({wrapped, 13'b0});
    assign slot_idx   = ({3'b0, slot_reg} << ws_reg) + {3'b0, elem_reg};
    assign elem_mask  = 3'((4'd1 << ws_reg) - 4'd1);

    assign status.skip      = !is_chr && (ws_reg == PRG_WS_INVALID);
    assign status.div_last  = (count_reg == '0);
    assign status.elem_last = (elem_reg == elem_mask);

    // Translate sums
    assign prg_sum = SUM_W'(prg_slots_reg[address_reg[14:13]]) + SUM_W'(address_reg[12:0]);
    assign chr_sum = SUM_W'(chr_slots_reg[address_reg[12:10]]) + SUM_W'(address_reg[9:0]);

    // Captured word and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            address_reg <= address;
            ws_reg      <= window_size;
            slot_reg    <= slot;
            page_reg    <= page;
        end
        if (cmd.elem_start)
        begin
            dividend_reg <= DIV_W'(bank_mag);
            neg_reg      <= bank_pos[15];
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= dividend_reg << 1;
            if (trial >= {1'b0, modulus})
            begin
                rem_reg <= CHR_BANKS_W'(trial - {1'b0, modulus});
            end
            else
            begin
                rem_reg <= CHR_BANKS_W'(trial);
            end
        end
        if (cmd.xlate)
        begin
            if (kind_reg == KIND_CHR_XLATE)
            begin
                offset_reg <= OFFSET_W'(chr_sum);
                target_reg <= TARGET_CHR_ROM;
                oor_reg    <= 1'b0;
            end
            else if (address_reg[15])
            begin
                offset_reg <= OFFSET_W'(prg_sum);
                target_reg <= TARGET_PRG_ROM;
                oor_reg    <= 1'b0;
            end
            else if (address_reg[14:13] == 2'b11)
            begin
                offset_reg <= OFFSET_W'(address_reg[12:0]);
                target_reg <= TARGET_PRG_RAM;
                oor_reg    <= 1'b0;
            end
            else
            begin
                offset_reg <= '0;
                target_reg <= TARGET_PRG_RAM;
                oor_reg    <= 1'b1;
            end
        end
    end

    // Control counters, configuration, slot tables and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_banks_reg <= PRG_BANKS_W'(2);
            chr_banks_reg <= CHR_BANKS_W'(8);
            elem_reg      <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            for (int i = 0; i < PRG_SLOTS; i++)
            begin
                prg_slots_reg[i] <= '0;
            end
            for (int i = 0; i < CHR_SLOTS; i++)
            begin
                chr_slots_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= cmd.xlate;
            if (cfg_we)
            begin
                if (cfg_index == CFG_PRG_ROM_BANKS)
                begin
                    prg_banks_reg <= cfg_data[PRG_BANKS_W-1:0];
                end
                else
                begin
                    chr_banks_reg <= cfg_data[CHR_BANKS_W-1:0];
                end
            end
            if (cmd.load)
            begin
                elem_reg <= '0;
            end
            if (cmd.elem_start)
            begin
                count_reg <= DIV_CNT_W'(DIV_W - 1);
            end
            else if (cmd.div_step)
            begin
                count_reg <= count_reg - 1'b1;
            end
            // Store the wrapped slot offset where the slot exists, then advance
            if (cmd.elem_write)
            begin
                elem_reg <= elem_reg + 1'b1;
                if (is_chr)
                begin
                    if (slot_idx < 6'(CHR_SLOTS))
                    begin
                        chr_slots_reg[slot_idx[2:0]] <= slot_value;
                    end
                end
                else if (slot_idx < 6'(PRG_SLOTS))
                begin
                    prg_slots_reg[slot_idx[1:0]] <= slot_value;
                end
            end
        end
    end

    assign done         = done_reg;
    assign offset       = offset_reg;
    assign target       = target_reg;
    assign out_of_range = oor_reg;

endmodule

FILE: hw/rtl/bank_switch_address_translator_core.sv
// Top level of the bank switch address translator.
// Joins the controller (bsat_ctrl) and the datapath (bsat_datapath); uses bsat_pkg.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   command  | start / busy       | kind, address, window_size, slot, page
//   result   | done (one cycle)   | offset, target, out_of_range
//   config   | cfg_we, cfg_index  | cfg_data
//
// A translate word is captured, then the slot table is looked up and the result
// registered; done is high in the cycle after that, when the next word can
// already be accepted. A set word is captured and then, for each slot of its
// window, the remainder unit is loaded, 15 restoring steps run and the slot is
// stored; a program set with window size 3 is captured and then dropped without
// storing a slot.
// Reset sets both slot tables to zero and the ROM sizes to 2 and 8 banks.
// The receiver cannot stall; each result is shown for exactly one cycle.
module bank_switch_address_translator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      kind,
    input  logic [15:0]                     address,
    input  logic [1:0]                      window_size,
    input  logic [2:0]                      slot,
    input  logic signed [10:0]              page,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [bsat_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            done,
    output logic [bsat_pkg::OFFSET_W-1:0]   offset,
    output logic [1:0]                      target,
    output logic                            out_of_range
);
    import bsat_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    // Sequence words
    bsat_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Tables, wrap and results
    bsat_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .address      (address),
        .window_size  (window_size),
        .slot         (slot),
        .page         (page),
        .done         (done),
        .offset       (offset),
        .target       (target),
        .out_of_range (out_of_range)
    );

endmodule
